// ----- rtl/core/mmagc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmagc_pkg: shared types and constants of the min-max linear AGC
// Widths of the pixel path and divider, pass codes, and the beat structs
// handed between the range tracker, the divider cells and the top level.
// ----------------------------------------------------------------------------
package mmagc_pkg;

  // Fixed port widths
  localparam int unsigned PIXEL_FIELD_W = 16;
  localparam int unsigned LEVEL_FIELD_W = 8;

  // Active pixel width and display width
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned OUT_BITS   = 8;

  // Numerator width of (2^OUT_BITS - 1) * (p - min)
  localparam int unsigned NUM_W = PIXEL_BITS + OUT_BITS;

  localparam logic [PIXEL_BITS-1:0] PIX_ALL_ONES = {PIXEL_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0]   OUT_MAX      = {OUT_BITS{1'b1}};

  // Pass selector carried on tuser
  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_APPLY   = 1'b1
  } cmd_e;

  // Apply-pixel classification from the range tracker
  typedef struct packed {
    logic                  fixed;        // level is fixed, skip the quotient
    logic [OUT_BITS-1:0]   fixed_level;
    logic [PIXEL_BITS-1:0] diff;         // p - frame_min
    logic [PIXEL_BITS-1:0] span;         // frame_max - frame_min
  } apply_class_t;

  // Beat moving along the divider chain
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                fixed;
    logic [OUT_BITS-1:0] fixed_level;
    logic [NUM_W-1:0]    rem;
    logic [NUM_W-1:0]    dsh;            // divisor aligned to this cell's bit
    logic [OUT_BITS-1:0] quo;
  } div_beat_t;

endpackage

// ----- rtl/core/mmagc_range.sv -----
// ----------------------------------------------------------------------------
// mmagc_range: running and frame range tracker
// Tracks the running minimum and maximum over measure-pass pixels, latches
// them as the frame range on the last pixel, and classifies apply pixels.
// ----------------------------------------------------------------------------
module mmagc_range (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           measure_i,
  input  logic                           last_i,
  input  logic [mmagc_pkg::PIXEL_BITS-1:0] pixel_i,
  output mmagc_pkg::apply_class_t        class_o
);
  import mmagc_pkg::*;

  logic [PIXEL_BITS-1:0] run_min_q, run_min_d;
  logic [PIXEL_BITS-1:0] run_max_q, run_max_d;
  logic [PIXEL_BITS-1:0] frm_min_q, frm_min_d;
  logic [PIXEL_BITS-1:0] frm_max_q, frm_max_d;
  logic [PIXEL_BITS-1:0] new_min;
  logic [PIXEL_BITS-1:0] new_max;
  logic                  flat;
  logic                  below;
  logic                  above;

  // Fold the pixel into the running range; latch and clear on the last one
  always_comb begin
    new_min   = (pixel_i < run_min_q) ? pixel_i : run_min_q;
    new_max   = (pixel_i > run_max_q) ? pixel_i : run_max_q;
    run_min_d = run_min_q;
    run_max_d = run_max_q;
    frm_min_d = frm_min_q;
    frm_max_d = frm_max_q;
    if (measure_i) begin
      if (last_i) begin
        frm_min_d = new_min;
        frm_max_d = new_max;
        run_min_d = PIX_ALL_ONES;
        run_max_d = '0;
      end else begin
        run_min_d = new_min;
        run_max_d = new_max;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= PIX_ALL_ONES;
      run_max_q <= '0;
      frm_min_q <= PIX_ALL_ONES;
      frm_max_q <= '0;
    end else begin
      run_min_q <= run_min_d;
      run_max_q <= run_max_d;
      frm_min_q <= frm_min_d;
      frm_max_q <= frm_max_d;
    end
  end

  // Classify an apply pixel against the frame range
  always_comb begin
    flat  = (frm_max_q <= frm_min_q);
    below = (pixel_i <= frm_min_q);
    above = (pixel_i >= frm_max_q);
    class_o.fixed       = flat || below || above;
    class_o.fixed_level = (!flat && !below && above) ? OUT_MAX : '0;
    class_o.diff        = pixel_i - frm_min_q;
    class_o.span        = frm_max_q - frm_min_q;
  end

endmodule

// ----- rtl/core/mmagc_cell.sv -----
// ----------------------------------------------------------------------------
// mmagc_cell: one restoring-division cell
// Resolves one quotient bit, subtracts the aligned divisor when it fits and
// hands the beat to the next cell with the divisor moved down one bit.
// ----------------------------------------------------------------------------
module mmagc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  mmagc_pkg::div_beat_t  beat_i,
  output mmagc_pkg::div_beat_t  beat_o
);
  import mmagc_pkg::*;

  div_beat_t beat_q, beat_d;
  logic      fits;

  // Compare, subtract and shift in the quotient bit
  always_comb begin
    fits        = (beat_i.rem >= beat_i.dsh);
    beat_d      = beat_i;
    beat_d.rem  = fits ? (beat_i.rem - beat_i.dsh) : beat_i.rem;
    beat_d.dsh  = beat_i.dsh >> 1;
    beat_d.quo  = {beat_i.quo[OUT_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- rtl/core/min_max_linear_agc.sv -----
// ----------------------------------------------------------------------------
// min_max_linear_agc: linear min-max contrast stretch, 16-bit to 8-bit
// Usage: stream each frame in twice on the slave channel. tuser selects the
// pass (0 measure, 1 apply), tlast marks the frame's last pixel of the pass.
// Measure beats update the running range and give no output; the last one
// latches the frame range. Apply beats each give one master beat with
// level = 255*(p-min)/(max-min), 0 below the range or for a flat range,
// 255 at or above the maximum; tlast copies the input tlast.
// Throughput: one pixel per cycle in both passes while the receiver takes
// every result. An apply pixel passes a classify stage, a numerator stage, a chain of 8 division
// cells (one quotient bit per cell), and the output register.
// A measure pixel is registered into the range when it is accepted, so
// apply pixels right behind the last measure pixel see the new range.
// Reset clears the running and frame ranges (flat, so levels read 0) and
// empties the pipeline. When the receiver stalls with a beat waiting, the
// whole pipeline holds and s_axis_tready_o drops until the beat is taken.
// ----------------------------------------------------------------------------
module min_max_linear_agc (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [mmagc_pkg::PIXEL_FIELD_W-1:0]  s_axis_tdata_i,   // [15:0] pixel
  input  logic                                 s_axis_tuser_i,   // [0] command
  input  logic                                 s_axis_tlast_i,   // last_pixel
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [mmagc_pkg::LEVEL_FIELD_W-1:0]  m_axis_tdata_o,   // [7:0] level
  output logic                                 m_axis_tlast_o    // frame_end
);
  import mmagc_pkg::*;

  logic                  en;
  logic                  accept;
  logic                  measure_acc;
  logic                  apply_acc;
  logic [PIXEL_BITS-1:0] pixel;
  apply_class_t          cls;

  // Front stage registers
  logic                  f_valid_q;
  logic                  f_last_q;
  apply_class_t          f_class_q;

  div_beat_t             beat_d;
  div_beat_t             chain [OUT_BITS+1];

  // Output register
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   out_level_q, out_level_d;
  logic                  out_last_q;

  // Advance the whole pipeline unless a result waits on a stalled receiver
  assign en          = !out_valid_q || m_axis_tready_i;
  assign accept      = s_axis_tvalid_i && en;
  assign measure_acc = accept && (s_axis_tuser_i == CMD_MEASURE);
  assign apply_acc   = accept && (s_axis_tuser_i == CMD_APPLY);
  assign pixel       = s_axis_tdata_i[PIXEL_BITS-1:0];

  mmagc_range u_range (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .measure_i (measure_acc),
    .last_i    (s_axis_tlast_i),
    .pixel_i   (pixel),
    .class_o   (cls)
  );

  // Capture the classified apply pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_last_q  <= 1'b0;
      f_class_q <= '0;
    end else if (en) begin
      f_valid_q <= apply_acc;
      f_last_q  <= s_axis_tlast_i;
      f_class_q <= cls;
    end
  end

  // Form the numerator (2^OUT_BITS - 1) * diff and align the divisor
  always_comb begin
    beat_d.valid       = f_valid_q;
    beat_d.last        = f_last_q;
    beat_d.fixed       = f_class_q.fixed;
    beat_d.fixed_level = f_class_q.fixed_level;
    beat_d.rem         = {f_class_q.diff, {OUT_BITS{1'b0}}}
                         - {{OUT_BITS{1'b0}}, f_class_q.diff};
    beat_d.dsh         = {{OUT_BITS{1'b0}}, f_class_q.span} << (OUT_BITS - 1);
    beat_d.quo         = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else if (en) begin
      chain[0] <= beat_d;
    end
  end

  // Division chain, one quotient bit per cell
  for (genvar i = 0; i < OUT_BITS; i++) begin : g_cell
    mmagc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  // Pick the fixed level or the quotient
  assign out_level_d = chain[OUT_BITS].fixed ? chain[OUT_BITS].fixed_level
                                             : chain[OUT_BITS].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_level_q <= '0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[OUT_BITS].valid;
      out_level_q <= out_level_d;
      out_last_q  <= chain[OUT_BITS].last;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = LEVEL_FIELD_W'(out_level_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- sim/mmagc_checker.sv -----
// ----------------------------------------------------------------------------
// mmagc_checker: level predictor and scoreboard for min_max_linear_agc
// Watches the slave and master channels and tracks the running and frame
// ranges from measure beats. Every apply beat yields an expected level and
// frame end. Output beats are compared in order against those expectations.
// ----------------------------------------------------------------------------
module mmagc_checker
  import mmagc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  input  logic [PIXEL_FIELD_W-1:0] s_tdata_i,   // [15:0] pixel
  input  logic                     s_tuser_i,   // [0] command
  input  logic                     s_tlast_i,   // last_pixel
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  input  logic [LEVEL_FIELD_W-1:0] m_tdata_i,   // [7:0] level
  input  logic                     m_tlast_i,   // frame_end
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_BITS-1:0] level;
    logic                frame_end;
  } level_beat_t;

  level_beat_t           expected_levels[$];
  logic [PIXEL_BITS-1:0] track_lo;
  logic [PIXEL_BITS-1:0] track_hi;
  logic [PIXEL_BITS-1:0] range_lo;
  logic [PIXEL_BITS-1:0] range_hi;
  int                    fail_count = 0;
  int                    checked = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t ns] level check: %s", $realtime, what);
    fail_count++;
  endtask

  // Stretch one apply pixel against the latched frame range
  function automatic logic [OUT_BITS-1:0] stretch_level(input logic [PIXEL_BITS-1:0] pix);
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    if (range_hi <= range_lo) return '0;
    if (pix <= range_lo) return '0;
    if (pix >= range_hi) return OUT_MAX;
    num = {{PIXEL_BITS{1'b0}}, OUT_MAX} * {{OUT_BITS{1'b0}}, pix - range_lo};
    quo = num / {{OUT_BITS{1'b0}}, range_hi - range_lo};
    return (quo > NUM_W'(OUT_MAX)) ? OUT_MAX : quo[OUT_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_beat_t           want;
    logic [PIXEL_BITS-1:0] pix;
    if (!rst_ni) begin
      track_lo = PIX_ALL_ONES;
      track_hi = '0;
      range_lo = PIX_ALL_ONES;
      range_hi = '0;
      expected_levels.delete();
    end else begin
      // Compare the output beat first: it can never come from this cycle's input
      if (m_tvalid_i && m_tready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected beat level=%0d last=%0b",
                                    m_tdata_i, m_tlast_i));
        end else begin
          want = expected_levels.pop_front();
          checked++;
          if (m_tdata_i !== want.level)
            report_mismatch($sformatf("level %0d, expected %0d", m_tdata_i, want.level));
          if (m_tlast_i !== want.frame_end)
            report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast_i, want.frame_end));
        end
      end

      // Advance the range model on each accepted pixel
      if (s_tvalid_i && s_tready_i) begin
        pix = s_tdata_i[PIXEL_BITS-1:0];
        if (cmd_e'(s_tuser_i) == CMD_MEASURE) begin
          if (pix < track_lo) track_lo = pix;
          if (pix > track_hi) track_hi = pix;
          if (s_tlast_i) begin
            range_lo = track_lo;
            range_hi = track_hi;
            track_lo = PIX_ALL_ONES;
            track_hi = '0;
          end
        end else begin
          want.level     = stretch_level(pix);
          want.frame_end = s_tlast_i;
          expected_levels.insert(expected_levels.size(), want);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_levels.size();
    checked_o    <= checked;
  end

endmodule

// ----- sim/tb_min_max_linear_agc.sv -----
// ----------------------------------------------------------------------------
// tb_min_max_linear_agc: stimulus and verdict for the min-max linear AGC
// Streams directed frames covering range extremes, flat and empty ranges and
// a mid-frame last mark, then random two-pass frames and broken sequences
// under three idle profiles. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_min_max_linear_agc;
  import mmagc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 32;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     s_valid = 1'b0;
  logic                     s_ready;
  logic [PIXEL_FIELD_W-1:0] s_data = '0;
  logic                     s_user = 1'b0;
  logic                     s_last = 1'b0;
  logic                     m_valid;
  logic                     m_ready = 1'b0;
  logic [LEVEL_FIELD_W-1:0] m_data;
  logic                     m_last;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int measure_pixels = 0;
  int apply_pixels = 0;

  min_max_linear_agc uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  mmagc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .s_tlast_i    (s_last),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tlast_i    (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL min_max_linear_agc");
      $finish;
    end
  end

  // Offer one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input cmd_e cmd, input logic [PIXEL_BITS-1:0] pix,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      s_data  <= PIXEL_FIELD_W'($urandom);
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= pix;
    s_user  <= cmd;
    s_last  <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    if (cmd == CMD_MEASURE) measure_pixels++;
    else apply_pixels++;
  endtask

  // Hold the sender until every expected level has come back
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed two-pass frames, plus broken measure runs and stray pixels
  task automatic run_random_phase(input int target);
    int start_count;
    int n;
    int lo;
    int hi;
    int span;
    int kind;
    start_count = measure_pixels + apply_pixels;
    while (measure_pixels + apply_pixels - start_count < target) begin
      kind = $urandom_range(99);
      n    = $urandom_range(12, 1);
      if (kind < 85) begin
        lo = $urandom_range(65535);
        case ($urandom_range(3))
          0: begin
            lo   = 0;
            span = 65535;
          end
          1: span = $urandom_range(255);
          2: span = 0;
          default: span = $urandom_range(65535);
        endcase
        hi = (lo + span > 65535) ? 65535 : lo + span;
        for (int k = 0; k < n; k++)
          send_pixel(CMD_MEASURE, PIXEL_BITS'($urandom_range(hi, lo)), k == n - 1);
        for (int k = 0; k < n; k++)
          send_pixel(CMD_APPLY,
                     PIXEL_BITS'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                                          : $urandom_range(hi, lo)),
                     k == n - 1);
      end else if (kind < 93) begin
        for (int k = 0; k < n; k++)
          send_pixel(CMD_MEASURE, PIXEL_BITS'($urandom_range(65535)),
                     $urandom_range(2) == 0);
      end else begin
        for (int k = 0; k < n; k++)
          send_pixel(CMD_APPLY, PIXEL_BITS'($urandom_range(65535)),
                     1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Apply before any measure pass: empty range reads zero
    send_pixel(CMD_APPLY, 16'h0000, 1'b0);
    send_pixel(CMD_APPLY, 16'hFFFF, 1'b1);
    // Full-scale range
    send_pixel(CMD_MEASURE, 16'h0000, 1'b0);
    send_pixel(CMD_MEASURE, 16'hFFFF, 1'b1);
    send_pixel(CMD_APPLY, 16'h0000, 1'b0);
    send_pixel(CMD_APPLY, 16'h0001, 1'b0);
    send_pixel(CMD_APPLY, 16'h8000, 1'b0);
    send_pixel(CMD_APPLY, 16'hFFFE, 1'b0);
    send_pixel(CMD_APPLY, 16'hFFFF, 1'b1);
    // Single-pixel frame gives a flat range
    send_pixel(CMD_MEASURE, 16'h1234, 1'b1);
    send_pixel(CMD_APPLY, 16'h1234, 1'b0);
    send_pixel(CMD_APPLY, 16'h1235, 1'b1);
    // Pixels below, above and on the range edges
    send_pixel(CMD_MEASURE, 16'd100, 1'b0);
    send_pixel(CMD_MEASURE, 16'd200, 1'b1);
    send_pixel(CMD_APPLY, 16'd50, 1'b0);
    send_pixel(CMD_APPLY, 16'd250, 1'b0);
    send_pixel(CMD_APPLY, 16'd150, 1'b0);
    send_pixel(CMD_APPLY, 16'd100, 1'b0);
    send_pixel(CMD_APPLY, 16'd200, 1'b1);
    // Last mark mid-frame latches and clears the trackers
    send_pixel(CMD_MEASURE, 16'd1000, 1'b0);
    send_pixel(CMD_MEASURE, 16'd2000, 1'b1);
    send_pixel(CMD_MEASURE, 16'd3000, 1'b0);
    send_pixel(CMD_MEASURE, 16'd2500, 1'b1);
    send_pixel(CMD_APPLY, 16'd2750, 1'b1);
    wait_drained();

    send_idle_pct = 33;
    recv_idle_pct = 53;
    run_random_phase(150);
    wait_drained();

    send_idle_pct = 53;
    recv_idle_pct = 33;
    run_random_phase(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(150);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d measure and %0d apply pixels, %0d levels compared,",
             measure_pixels, apply_pixels, checked);
    $display("under three sender/receiver idle profiles with full drains between.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS min_max_linear_agc");
    end else begin
      $display("FAIL min_max_linear_agc");
    end
    $finish;
  end

endmodule
